FILE: hw/rtl/egl_pkg.sv
package egl_pkg;

    localparam int DATA_W        = 32;
    localparam int LCM_W         = 64;
    localparam int OPERAND_W_DEF = 32;
    localparam int IN_TDATA_W    = 2 * DATA_W;
    localparam int OUT_TDATA_W   = DATA_W + LCM_W;
    localparam int PC_W          = 4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_START,
        OP_SWAP,
        OP_LCM_START,
        OP_MUL,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_B_ZERO,
        COND_DIV_BUSY,
        COND_REM_NZ,
        COND_A_ZERO,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] ST_CHECK = 4'd1;
    localparam logic [PC_W-1:0] ST_DIV   = 4'd2;
    localparam logic [PC_W-1:0] ST_WAIT  = 4'd3;
    localparam logic [PC_W-1:0] ST_STEP  = 4'd4;
    localparam logic [PC_W-1:0] ST_LCM   = 4'd5;
    localparam logic [PC_W-1:0] ST_LWAIT = 4'd6;
    localparam logic [PC_W-1:0] ST_MUL   = 4'd7;
    localparam logic [PC_W-1:0] ST_EMIT  = 4'd8;
    localparam logic [PC_W-1:0] ST_HOLD  = 4'd9;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            ST_IDLE:  w = '{OP_LOAD,      COND_NO_IN,    ST_IDLE};
            ST_CHECK: w = '{OP_NONE,      COND_B_ZERO,   ST_EMIT};
            ST_DIV:   w = '{OP_DIV_START, COND_NEVER,    ST_IDLE};
            ST_WAIT:  w = '{OP_NONE,      COND_DIV_BUSY, ST_WAIT};
            ST_STEP:  w = '{OP_SWAP,      COND_REM_NZ,   ST_DIV};
            ST_LCM:   w = '{OP_LCM_START, COND_A_ZERO,   ST_EMIT};
            ST_LWAIT: w = '{OP_NONE,      COND_DIV_BUSY, ST_LWAIT};
            ST_MUL:   w = '{OP_MUL,       COND_NEVER,    ST_IDLE};
            ST_EMIT:  w = '{OP_EMIT,      COND_OUT_FREE, ST_IDLE};
            ST_HOLD:  w = '{OP_NONE,      COND_ALWAYS,   ST_EMIT};
            default:  w = '{OP_NONE,      COND_ALWAYS,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/egl_div.sv
module egl_div #(
    parameter int W = egl_pkg::OPERAND_W_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quot,
    output logic [W-1:0] rem
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [W-1:0]     quot_reg, quot_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [W:0]       shifted;
    logic [W:0]       diff;

    assign shifted = {rem_reg, quot_reg[W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            count_next = CNT_W'(W);
            quot_next  = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CNT_W'(1);
            if (!diff[W])
            begin
                rem_next  = diff[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[W-1:0];
                quot_next = {quot_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign busy = (count_reg != '0);
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

FILE: hw/rtl/euclid_gcd_lcm_top.sv
// Sequential gcd/lcm engine: one item at a time, s_axis_tready high only when idle.
// Each Euclid remainder step runs on the shared radix-2 divider (W = OPERAND_WIDTH).
// A zero divisor skips the divider and goes straight to the result; a zero first operand
// skips the lcm division after the remainder steps and gives an lcm of zero.
// Input frees once the result register takes the result; an untaken result there stalls the engine.
// Reset (rst_n, async, active low) returns the sequencer to idle and empties the result register.
module euclid_gcd_lcm_top #(
    parameter int OPERAND_WIDTH = egl_pkg::OPERAND_W_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // first_value [31:0], second_value [63:32]
    input  logic [egl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // gcd_value [31:0], lcm_value [95:32]
    output logic [egl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // zero_divisor [0]
    output logic                             m_axis_tuser
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int DW = egl_pkg::DATA_W;
    localparam int LW = egl_pkg::LCM_W;

    egl_pkg::ctrl_t ctrl;

    logic [egl_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [W-1:0]             a_reg, b_reg, a0_reg, b0_reg;
    logic [W-1:0]             g_reg;
    logic [PW-1:0]            l_reg;
    logic                     err_reg;
    logic                     out_valid_reg;
    logic [DW-1:0]            out_gcd_reg;
    logic [LW-1:0]            out_lcm_reg;
    logic                     out_err_reg;

    logic                     div_start;
    logic                     div_busy;
    logic [W-1:0]             div_dividend;
    logic [W-1:0]             div_quot;
    logic [W-1:0]             div_rem;
    logic [PW-1:0]            product;
    logic                     out_free;
    logic                     cond_hit;
    logic                     in_accept;

    assign ctrl      = egl_pkg::ucode(pc_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign in_accept = (ctrl.op == egl_pkg::OP_LOAD) && s_axis_tvalid;

    always_comb
    begin
        case (ctrl.cond)
            egl_pkg::COND_NEVER:    cond_hit = 1'b0;
            egl_pkg::COND_ALWAYS:   cond_hit = 1'b1;
            egl_pkg::COND_NO_IN:    cond_hit = !s_axis_tvalid;
            egl_pkg::COND_B_ZERO:   cond_hit = (b_reg == '0);
            egl_pkg::COND_DIV_BUSY: cond_hit = div_busy;
            egl_pkg::COND_REM_NZ:   cond_hit = (div_rem != '0);
            egl_pkg::COND_A_ZERO:   cond_hit = (a0_reg == '0);
            egl_pkg::COND_OUT_FREE: cond_hit = out_free;
            default:                cond_hit = 1'b1;
        endcase
        pc_next = cond_hit ? ctrl.target : pc_reg + egl_pkg::PC_W'(1);
    end

    assign div_start    = (ctrl.op == egl_pkg::OP_DIV_START) ||
                          ((ctrl.op == egl_pkg::OP_LCM_START) && (a0_reg != '0));
    assign div_dividend = (ctrl.op == egl_pkg::OP_LCM_START) ? a0_reg : a_reg;
    assign product      = PW'(div_quot) * PW'(b0_reg);

    egl_div #(
        .W (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (b_reg),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= egl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if ((ctrl.op == egl_pkg::OP_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            egl_pkg::OP_LOAD:
            begin
                if (in_accept)
                begin
                    a_reg   <= s_axis_tdata[W-1:0];
                    b_reg   <= s_axis_tdata[DW+W-1:DW];
                    a0_reg  <= s_axis_tdata[W-1:0];
                    b0_reg  <= s_axis_tdata[DW+W-1:DW];
                    err_reg <= (s_axis_tdata[DW+W-1:DW] == '0);
                    g_reg   <= '0;
                    l_reg   <= '0;
                end
            end
            egl_pkg::OP_SWAP:
            begin
                if (div_rem != '0)
                begin
                    a_reg <= b_reg;
                    b_reg <= div_rem;
                end
            end
            egl_pkg::OP_LCM_START:
            begin
                g_reg <= b_reg;
            end
            egl_pkg::OP_MUL:
            begin
                l_reg <= product;
            end
            egl_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    out_gcd_reg <= DW'(g_reg);
                    out_lcm_reg <= LW'(l_reg);
                    out_err_reg <= err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_axis_tready = (ctrl.op == egl_pkg::OP_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_lcm_reg, out_gcd_reg};
    assign m_axis_tuser  = out_err_reg;

endmodule

FILE: hw/rtl/egl_checker.sv
module egl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [egl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    localparam int DW = egl_pkg::DATA_W;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in flight");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero divisor result carries nonzero data");

    a_lcm_needs_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[egl_pkg::OUT_TDATA_W-1:DW] != '0)
        |-> (m_axis_tdata[DW-1:0] != '0) && !m_axis_tuser)
        else $error("nonzero lcm with zero gcd or error");

endmodule

bind euclid_gcd_lcm_top egl_checker u_egl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int DATA_W      = egl_pkg::DATA_W;
    localparam int LCM_W       = egl_pkg::LCM_W;
    localparam int IN_TDATA_W  = egl_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = egl_pkg::OUT_TDATA_W;

    localparam int OPW = egl_pkg::OPERAND_W_DEF;
    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_CYCLES = 2000;

    typedef struct {
        logic [DATA_W-1:0] gcd;
        logic [LCM_W-1:0]  lcm;
        logic              zero_div;
    } gcd_lcm_t;

    class gcd_lcm_scoreboard;
        gcd_lcm_t expected_results[$];
        int       mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function gcd_lcm_t predict_gcd_lcm(logic [DATA_W-1:0] a_in, logic [DATA_W-1:0] b_in);
            logic [63:0]       mask;
            logic [DATA_W-1:0] a0;
            logic [DATA_W-1:0] b0;
            logic [DATA_W-1:0] x;
            logic [DATA_W-1:0] y;
            logic [DATA_W-1:0] r;
            gcd_lcm_t          res;
            mask = (64'd1 << OPW) - 64'd1;
            a0 = a_in & mask[DATA_W-1:0];
            b0 = b_in & mask[DATA_W-1:0];
            res.gcd = '0;
            res.lcm = '0;
            res.zero_div = 1'b0;
            if (b0 == '0)
            begin
                res.zero_div = 1'b1;
            end
            else
            begin
                x = a0;
                y = b0;
                r = x % y;
                while (r != '0)
                begin
                    x = y;
                    y = r;
                    r = x % y;
                end
                res.gcd = y;
                if (a0 != '0)
                    res.lcm = {32'd0, a0 / y} * {32'd0, b0};
            end
            return res;
        endfunction

        function void note_operands(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
            expected_results.push_back(predict_gcd_lcm(a, b));
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
            gcd_lcm_t exp_res;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result tdata=%h tuser=%b", tdata, tuser));
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (tdata[DATA_W-1:0] !== exp_res.gcd)
                    report_mismatch($sformatf("gcd got %h want %h",
                                              tdata[DATA_W-1:0], exp_res.gcd));
                if (tdata[DATA_W +: LCM_W] !== exp_res.lcm)
                    report_mismatch($sformatf("lcm got %h want %h",
                                              tdata[DATA_W +: LCM_W], exp_res.lcm));
                if (tuser !== exp_res.zero_div)
                    report_mismatch($sformatf("zero_divisor got %b want %b",
                                              tuser, exp_res.zero_div));
            end
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic [DATA_W-1:0] fib_seq[48];

    gcd_lcm_scoreboard sb = new();

    euclid_gcd_lcm_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    task send_operands(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_operands(a, b);
    endtask

    task send_random_operands();
        int                kind;
        int                idx;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] g;
        kind = $urandom_range(0, 99);
        a = $urandom;
        b = $urandom;
        if (kind < 30)
        begin
        end
        else if (kind < 45)
        begin
            g = $urandom_range(1, 65535);
            a = g * $urandom_range(0, 65535);
            b = g * $urandom_range(1, 65535);
        end
        else if (kind < 55)
        begin
            a = $urandom_range(0, 20);
            b = $urandom_range(0, 20);
        end
        else if (kind < 65)
        begin
            idx = $urandom_range(1, 46);
            if ($urandom_range(0, 1) == 0)
            begin
                a = fib_seq[idx + 1];
                b = fib_seq[idx];
            end
            else
            begin
                a = fib_seq[idx];
                b = fib_seq[idx + 1];
            end
        end
        else if (kind < 73)
        begin
            if ($urandom_range(0, 1) == 0)
                a = '0;
            else
                b = '0;
        end
        else if (kind < 81)
        begin
            a = a << $urandom_range(0, 31);
            b = b << $urandom_range(0, 31);
        end
        else if (kind < 91)
        begin
            b = $urandom_range(1, 100000);
            a = b * $urandom_range(0, 40000);
        end
        else
        begin
            a = 32'hFFFF_FFFF - $urandom_range(0, 15);
            b = 32'hFFFF_FFFF - $urandom_range(0, 15);
        end
        send_operands(a, b);
    endtask

    initial
    begin
        #(50_000_000);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        fib_seq[0] = 32'd0;
        fib_seq[1] = 32'd1;
        for (int i = 2; i < 48; i++)
            fib_seq[i] = fib_seq[i - 1] + fib_seq[i - 2];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 12;
        rx_idle_pct = 81;
        send_operands(32'd0, 32'd0);
        send_operands(32'd5, 32'd0);
        send_operands(32'hFFFF_FFFF, 32'd0);
        send_operands(32'd0, 32'd7);
        send_operands(32'd0, 32'hFFFF_FFFF);
        send_operands(32'd1, 32'd1);
        send_operands(32'd1, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'd1);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_operands(32'd2971215073, 32'd1836311903);
        send_operands(32'd1836311903, 32'd2971215073);
        send_operands(32'd12, 32'd18);
        send_operands(32'h8000_0000, 32'h4000_0000);
        send_operands(32'd4294967291, 32'd4294967279);
        send_operands(32'h5555_5555, 32'hAAAA_AAAA);
        send_operands(32'd7, 32'd21);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 81 : 0;
            rx_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 12 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
                send_random_operands();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
